// ===== rtl/core/url_percent_codec_defines.svh =====
// Assertion macros for the url_percent_codec checker file, upc_checker.sv.
// Needs a clock and an active-low reset name passed in by the caller.
`ifndef URL_PERCENT_CODEC_DEFINES_SVH
`define URL_PERCENT_CODEC_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/upc_pkg.sv =====
// Package for url_percent_codec: types, character constants and helpers.
// Used by the interfaces, the core modules and the checker.
package upc_pkg;

  localparam int unsigned MaxResults = 3;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] cnt_t;

  // Decode progress through a percent escape.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  // Up to three result bytes of one request; slot 0 leaves first.
  typedef struct packed {
    byte_t [MaxResults-1:0] bytes;
    logic  [MaxResults-1:0] lasts;
    cnt_t                   cnt;
  } group_t;

  localparam byte_t ChPercent = 8'h25;
  localparam byte_t ChDash    = 8'h2D;
  localparam byte_t ChUnder   = 8'h5F;
  localparam byte_t ChDot     = 8'h2E;
  localparam byte_t ChTilde   = 8'h7E;
  localparam byte_t ChZero    = 8'h30;
  localparam byte_t ChNine    = 8'h39;
  localparam byte_t ChUpA     = 8'h41;
  localparam byte_t ChUpF     = 8'h46;
  localparam byte_t ChUpZ     = 8'h5A;
  localparam byte_t ChLoA     = 8'h61;
  localparam byte_t ChLoF     = 8'h66;
  localparam byte_t ChLoZ     = 8'h7A;
  localparam byte_t HexLetterBase = 8'h37;  // 'A' minus ten

  function automatic logic is_digit(input byte_t b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

  function automatic logic is_hex(input byte_t b);
    return is_digit(b) || ((b >= ChUpA) && (b <= ChUpF)) ||
           ((b >= ChLoA) && (b <= ChLoF));
  endfunction

  // Value of a hex digit of either case; only meaningful when is_hex holds.
  function automatic logic [3:0] hex_val(input byte_t b);
    if (is_digit(b)) begin
      return b[3:0];
    end
    return 4'(b[3:0] + 4'd9);
  endfunction

  function automatic logic is_plain(input byte_t b);
    return is_digit(b) || ((b >= ChUpA) && (b <= ChUpZ)) ||
           ((b >= ChLoA) && (b <= ChLoZ)) || (b == ChDash) ||
           (b == ChUnder) || (b == ChDot) || (b == ChTilde);
  endfunction

  function automatic byte_t hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return ChZero | {4'd0, nib};
    end
    return 8'(HexLetterBase + {4'd0, nib});
  endfunction

endpackage

// ===== rtl/core/upc_in_if.sv =====
// Input channel of url_percent_codec: valid/ready handshake with one byte.
// Depends on upc_pkg for the byte type.
interface upc_in_if
  import upc_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/upc_out_if.sv =====
// Output channel of url_percent_codec: valid/ready handshake with one byte.
// Depends on upc_pkg for the byte type.
interface upc_out_if
  import upc_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/core/url_percent_codec.sv =====
// URL percent encoder/decoder. Each request is one byte; the result leaves as
// one byte per cycle while the output is ready. A request is held in the input
// register and is then converted into the result register, from which its first
// result byte is offered. Requests are taken one per cycle while each yields at
// most one byte and the output is ready; an encoded escape yields three bytes and
// holds the input while the result register hands them out. A decode percent or
// first digit yields no byte. Write decode_mode only while the block is empty; any
// write drops a pending escape.
module url_percent_codec
  import upc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  upc_in_if.sink     in_i,
  upc_out_if.source  out_o
);

  logic   in_vld_q;
  byte_t  in_byte_q;
  logic   in_last_q;
  logic   mode_q;
  phase_e phase_q, phase_d;
  byte_t  held_q, held_d;
  group_t group;
  logic   free;
  logic   advance;
  logic   accept;

  // Input register moves into the result register when that has room.
  assign advance    = in_vld_q && free;
  assign in_i.ready = !in_vld_q || free;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= in_i.in_byte;
      in_last_q <= in_i.in_last;
    end
  end

  // Mode register and escape state; a write clears any pending escape.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      phase_q <= PH_IDLE;
      held_q  <= '0;
    end else if (cfg_we_i) begin
      mode_q  <= cfg_wdata_i;
      phase_q <= PH_IDLE;
      held_q  <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  upc_expand u_expand (
    .decode_mode_i (mode_q),
    .phase_i       (phase_q),
    .held_i        (held_q),
    .byte_i        (in_byte_q),
    .last_i        (in_last_q),
    .group_o       (group),
    .phase_o       (phase_d),
    .held_o        (held_d)
  );

  upc_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .group_i (group),
    .free_o  (free),
    .out_o   (out_o)
  );

endmodule

// ===== rtl/core/upc_expand.sv =====
// Combinational conversion of one request into up to three result bytes.
// Depends on upc_pkg for types, character constants and helpers.
module upc_expand
  import upc_pkg::*;
(
  input  logic   decode_mode_i,
  input  phase_e phase_i,
  input  byte_t  held_i,
  input  byte_t  byte_i,
  input  logic   last_i,
  output group_t group_o,
  output phase_e phase_o,
  output byte_t  held_o
);

  logic  use_idle;
  logic  idle_emit;
  cnt_t  pfx_n;
  byte_t pfx0;
  byte_t pfx1;

  // A lone percent that does not end the string opens an escape.
  assign idle_emit = !((byte_i == ChPercent) && !last_i);

  always_comb begin
    group_o  = '0;
    phase_o  = PH_IDLE;
    held_o   = '0;
    use_idle = 1'b0;
    pfx_n    = 2'd0;
    pfx0     = ChPercent;
    pfx1     = held_i;

    if (!decode_mode_i) begin
      // Encode: plain bytes pass, everything else becomes %HH.
      if (is_plain(byte_i)) begin
        group_o.bytes[0] = byte_i;
        group_o.lasts[0] = last_i;
        group_o.cnt      = 2'd1;
      end else begin
        group_o.bytes[0] = ChPercent;
        group_o.bytes[1] = hex_char(byte_i[7:4]);
        group_o.bytes[2] = hex_char(byte_i[3:0]);
        group_o.lasts[2] = last_i;
        group_o.cnt      = 2'd3;
      end
    end else begin
      unique case (phase_i)
        PH_PCT: begin
          if (is_hex(byte_i)) begin
            if (last_i) begin
              // String ends after the first digit: flush literally.
              group_o.bytes[0] = ChPercent;
              group_o.bytes[1] = byte_i;
              group_o.lasts[1] = 1'b1;
              group_o.cnt      = 2'd2;
            end else begin
              phase_o = PH_DIGIT;
              held_o  = byte_i;
            end
          end else begin
            use_idle = 1'b1;
            pfx_n    = 2'd1;
          end
        end
        PH_DIGIT: begin
          if (is_hex(byte_i) && is_hex(held_i)) begin
            group_o.bytes[0] = {hex_val(held_i), hex_val(byte_i)};
            group_o.lasts[0] = last_i;
            group_o.cnt      = 2'd1;
          end else begin
            use_idle = 1'b1;
            pfx_n    = 2'd2;
          end
        end
        default: begin
          use_idle = 1'b1;
        end
      endcase

      // Broken escape prefix, then the byte handled with no escape pending.
      if (use_idle) begin
        group_o.bytes[0] = pfx0;
        group_o.bytes[1] = pfx1;
        if (idle_emit) begin
          group_o.bytes[pfx_n] = byte_i;
          group_o.lasts[pfx_n] = last_i;
          group_o.cnt          = 2'(pfx_n + 2'd1);
        end else begin
          group_o.cnt = pfx_n;
          phase_o     = PH_PCT;
        end
      end
    end
  end

endmodule

// ===== rtl/core/upc_outbuf.sv =====
// Result register of url_percent_codec: holds one request's result bytes
// and hands them out one per cycle while the output is ready. Depends on upc_pkg and upc_out_if.
module upc_outbuf
  import upc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  group_t           group_i,
  output logic             free_o,
  upc_out_if.source        out_o
);

  byte_t [MaxResults-1:0] bytes_q, bytes_d;
  logic  [MaxResults-1:0] lasts_q, lasts_d;
  cnt_t                   cnt_q, cnt_d;
  logic                   take;

  assign out_o.valid    = (cnt_q != 2'd0);
  assign out_o.out_byte = bytes_q[0];
  assign out_o.out_last = lasts_q[0];
  assign take           = out_o.valid && out_o.ready;

  // Free when empty or when the final held byte leaves this cycle.
  assign free_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);

  // Load a new group, or shift the next byte to the head.
  always_comb begin
    bytes_d = bytes_q;
    lasts_d = lasts_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      bytes_d = group_i.bytes;
      lasts_d = group_i.lasts;
      cnt_d   = group_i.cnt;
    end else if (take) begin
      bytes_d = {bytes_q[MaxResults-1], bytes_q[MaxResults-1:1]};
      lasts_d = {lasts_q[MaxResults-1], lasts_q[MaxResults-1:1]};
      cnt_d   = 2'(cnt_q - 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    lasts_q <= lasts_d;
  end

endmodule

// ===== rtl/core/upc_checker.sv =====
// Port-level checks for url_percent_codec, attached by a bind statement.
// Depends on upc_pkg and the macros in url_percent_codec_defines.svh.
`include "url_percent_codec_defines.svh"

module upc_checker
  import upc_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  cfg_we_i,
  input logic  cfg_wdata_i,
  input logic  in_valid_i,
  input logic  in_ready_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input byte_t out_byte_i,
  input logic  out_last_i
);

  logic mode_q;
  logic enc_byte_ok;

  // Track the mode from the configuration writes seen on the port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign enc_byte_ok = is_plain(out_byte_i) || (out_byte_i == ChPercent);

  // A stalled result holds its byte.
  `UPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_byte_i) && $stable(out_last_i), "stalled result changed")

  // With nothing waiting at the output, the input is never blocked.
  `UPC_ASSERT_NOW(a_in_ready, clk_i, rst_ni, !out_valid_i && !in_valid_i || !out_valid_i,
    in_ready_i, "input blocked while output empty")

  // Encoding emits only unreserved characters and percent signs.
  `UPC_ASSERT_NOW(a_enc_set, clk_i, rst_ni, !mode_q && out_valid_i,
    enc_byte_ok, "encoder emitted a reserved byte")

  // An encoded percent always opens an escape, so it never ends a string.
  `UPC_ASSERT_NOW(a_enc_pct, clk_i, rst_ni, !mode_q && out_valid_i && (out_byte_i == ChPercent),
    !out_last_i, "encoder ended a string on a percent")

endmodule

bind url_percent_codec upc_checker u_upc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.out_last)
);
